### hdl/slwm_pkg.sv
// Shared types and constants for the sliding window median filter.
`timescale 1ns / 1ps
package slwm_pkg;

  localparam int SAMPLE_W   = 31;
  localparam int DATA_W     = 32;
  localparam int WINDOW_DEF = 64;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Handed from a cell to its right neighbor each cycle
  typedef struct packed {
    sample_t value;     // cell contents
    logic    del_le;    // oldest entry sits at or left of this cell
    logic    keep_lo;   // this cell's post-removal value is <= new sample
  } link_t;

endpackage

### hdl/slwm_store.sv
// Sample history memory: one write port, one registered read port.
`timescale 1ns / 1ps
module slwm_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  slwm_pkg::sample_t   wr_data,
  input  logic [ADDR_W-1:0]   rd_addr,
  output slwm_pkg::sample_t   rd_data
);
  import slwm_pkg::*;

  sample_t mem [DEPTH];

  // Write new sample, register read of the next oldest
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/slwm_cell.sv
// One cell of the sorted chain: holds a value and the history slot it came from.
`timescale 1ns / 1ps
module slwm_cell #(
  parameter int              TAG_W = 6,
  parameter logic [TAG_W-1:0] INDEX = '0,
  parameter bit              LAST  = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  slwm_pkg::sample_t   sample,
  input  slwm_pkg::sample_t   oldest,
  input  logic [TAG_W-1:0]    new_tag,
  input  slwm_pkg::link_t     left_in,
  input  logic [TAG_W-1:0]    left_tag,
  input  slwm_pkg::sample_t   right_value,
  input  logic [TAG_W-1:0]    right_tag,
  output slwm_pkg::link_t     link_out,
  output logic [TAG_W-1:0]    tag,
  output slwm_pkg::sample_t   value_next
);
  import slwm_pkg::*;

  sample_t          value;
  sample_t          post_here;
  sample_t          post_left;
  logic [TAG_W-1:0] tag_here;
  logic [TAG_W-1:0] tag_left;
  logic [TAG_W-1:0] tag_next;
  logic             del_le;
  logic             keep_lo;
  logic             push_hi;

  // Equal values sit oldest first, so the oldest entry is the leftmost one >= it
  assign del_le = (value >= oldest);

  // Contents of this slot and of the left slot once the oldest entry is dropped
  assign post_here = del_le ? right_value : value;
  assign tag_here  = del_le ? right_tag   : tag;
  assign post_left = left_in.del_le ? value : left_in.value;
  assign tag_left  = left_in.del_le ? tag   : left_tag;

  // New sample goes right of all entries <= it
  assign keep_lo = !LAST && (post_here <= sample);
  assign push_hi = !left_in.keep_lo;

  always_comb begin
    if (keep_lo) begin
      value_next = post_here;
      tag_next   = tag_here;
    end else if (push_hi) begin
      value_next = post_left;
      tag_next   = tag_left;
    end else begin
      value_next = sample;
      tag_next   = new_tag;
    end
  end

  assign link_out = '{value: value, del_le: del_le, keep_lo: keep_lo};

  // Hold contents, advance on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      tag   <= INDEX;
    end else if (shift) begin
      value <= value_next;
      tag   <= tag_next;
    end
  end

endmodule

### hdl/sliding_window_median_top.sv
// The median of a beat is registered onto m_tdata in the cycle after the beat is taken.
// Throughput: one sample per cycle unless the output stalls; the sorted cell chain
// updates on each accepted beat, and the history read of the next oldest is registered.
// Reset (synchronous): the chain holds WINDOW zeros and the write slot returns to zero;
// the history memory is not cleared, unwritten slots read as zero through a wrap flag.
`timescale 1ns / 1ps
module sliding_window_median_top #(
  parameter int WINDOW = slwm_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [slwm_pkg::DATA_W-1:0] s_tdata,   // [30:0] sample
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [slwm_pkg::DATA_W-1:0] m_tdata    // [30:0] median
);
  import slwm_pkg::*;

  localparam int TAG_W = $clog2(WINDOW);
  localparam int MID   = WINDOW / 2;
  localparam logic [TAG_W-1:0] LAST_POS = TAG_W'(WINDOW - 1);

  logic             accept;
  sample_t          sample;
  logic [TAG_W-1:0] wr_pos;
  logic [TAG_W-1:0] wr_pos_inc;
  logic [TAG_W-1:0] wr_pos_next;
  logic             wrapped;
  logic             wrapped_next;
  logic             oldest_ok;
  sample_t          oldest_rd;
  sample_t          oldest;
  sample_t          median;

  link_t            links  [WINDOW];
  logic [TAG_W-1:0] tags   [WINDOW];
  sample_t          nexts  [WINDOW];

  assign sample   = s_tdata[SAMPLE_W-1:0];
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Advance write slot and note the first wrap
  assign wr_pos_inc   = (wr_pos == LAST_POS) ? '0 : wr_pos + 1'b1;
  assign wr_pos_next  = accept ? wr_pos_inc : wr_pos;
  assign wrapped_next = wrapped || (accept && (wr_pos == LAST_POS));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos    <= '0;
      wrapped   <= 1'b0;
      oldest_ok <= 1'b0;
    end else begin
      wr_pos    <= wr_pos_next;
      wrapped   <= wrapped_next;
      oldest_ok <= wrapped_next;
    end
  end

  slwm_store #(
    .DEPTH  (WINDOW),
    .ADDR_W (TAG_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wr_pos),
    .wr_data (sample),
    .rd_addr (wr_pos_next),
    .rd_data (oldest_rd)
  );

  // Slots never written read as zero, matching the chain's reset zeros
  assign oldest = oldest_ok ? oldest_rd : '0;

  // Sorted chain, smallest on the left
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    link_t            left_link;
    logic [TAG_W-1:0] left_tag;
    sample_t          right_value;
    logic [TAG_W-1:0] right_tag;

    if (i == 0) begin : g_head
      assign left_link = '{value: '0, del_le: 1'b0, keep_lo: 1'b1};
      assign left_tag  = '0;
    end else begin : g_body
      assign left_link = links[i-1];
      assign left_tag  = tags[i-1];
    end

    if (i == WINDOW - 1) begin : g_tail
      assign right_value = '0;
      assign right_tag   = '0;
    end else begin : g_mid
      assign right_value = links[i+1].value;
      assign right_tag   = tags[i+1];
    end

    slwm_cell #(
      .TAG_W (TAG_W),
      .INDEX (TAG_W'(i)),
      .LAST  (i == WINDOW - 1)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift       (accept),
      .sample      (sample),
      .oldest      (oldest),
      .new_tag     (wr_pos),
      .left_in     (left_link),
      .left_tag    (left_tag),
      .right_value (right_value),
      .right_tag   (right_tag),
      .link_out    (links[i]),
      .tag         (tags[i]),
      .value_next  (nexts[i])
    );
  end

  // Output register: load the middle cell's new value on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      median <= nexts[MID];
    end
  end

  assign m_tdata = {{(DATA_W - SAMPLE_W){1'b0}}, median};

endmodule

### sim/tb_sliding_window_median_top.sv
// Self-checking testbench for the sliding window median filter.
`timescale 1ns / 1ps
module tb_sliding_window_median_top;
  import slwm_pkg::*;

  localparam int WINDOW       = 64;
  localparam int RANDOM_BEATS = 1250;
  localparam int TAIL_BEATS   = 150;
  localparam int DRAIN_CYCLES = 8;

  // Track the last WINDOW samples and the medians still owed by the block
  class median_scoreboard;
    sample_t history [WINDOW];
    int      slot;
    sample_t owed_medians [$];
    int      errors;

    function new();
      foreach (history[i]) history[i] = '0;
      slot   = 0;
      errors = 0;
    endfunction

    // Element at rank WINDOW/2 of the window in ascending order
    function sample_t window_median();
      int below;
      int at_most;
      for (int i = 0; i < WINDOW; i++) begin
        below   = 0;
        at_most = 0;
        for (int j = 0; j < WINDOW; j++) begin
          if (history[j] < history[i]) below++;
          if (history[j] <= history[i]) at_most++;
        end
        if (below <= WINDOW / 2 && at_most > WINDOW / 2) return history[i];
      end
      return '0;
    endfunction

    // Overwrite the oldest entry and queue the new median
    function void note_sample(logic [DATA_W-1:0] beat);
      history[slot] = beat[SAMPLE_W-1:0];
      slot          = (slot + 1) % WINDOW;
      owed_medians.push_back(window_median());
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      if (owed_medians.size() == 0) begin
        $display("%0t: unexpected median beat, got %0d", $time, got);
        errors++;
        return;
      end
      want = owed_medians.pop_front();
      if (got !== want) begin
        $display("%0t: median expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return owed_medians.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata;   // [30:0] sample
  logic              m_tvalid;
  logic              m_tready;
  logic [DATA_W-1:0] m_tdata;   // [30:0] median

  median_scoreboard  sb;
  logic              tail_phase;
  int                send_calm;

  // Random segment state
  int                seg_mode;
  int                seg_left;
  logic [DATA_W-1:0] seg_val;
  logic [DATA_W-1:0] seg_alt;
  logic              seg_flip;

  sliding_window_median_top #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Note accepted samples and check accepted medians
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata);
      if (m_tvalid && m_tready) sb.check_median(m_tdata[SAMPLE_W-1:0]);
    end
  end

  // Stall the result side in bursts, never in the tail phase
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tail_phase) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_tready <= 1'b0;
      end else begin
        run_left = $urandom_range(0, 40);
        m_tready <= 1'b1;
      end
    end
  end

  // Hold one sample until the block takes it
  task automatic send_sample(input logic [DATA_W-1:0] beat);
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid for a random burst now and then
  task automatic sender_idle();
    if (tail_phase) return;
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end else begin
      send_calm = $urandom_range(0, 30);
    end
  endtask

  // Stop sending until every owed median has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Next sample from a run of random length and random shape
  function logic [DATA_W-1:0] next_random_beat();
    logic [DATA_W-1:0] beat;
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 7);
      seg_left = $urandom_range(16, 96);
      seg_val  = $urandom();
      seg_alt  = $urandom_range(0, 15);
      seg_flip = 1'b0;
    end
    seg_left--;
    case (seg_mode)
      0: beat = $urandom();
      1: beat = $urandom_range(0, 7);
      2: beat = 32'h7FFF_FFFF - $urandom_range(0, 7);
      3: begin
        seg_val = seg_val + $urandom_range(0, 3);
        beat    = seg_val;
      end
      4: begin
        seg_val = seg_val - $urandom_range(0, 3);
        beat    = seg_val;
      end
      5: beat = seg_val;
      6: begin
        seg_flip = ~seg_flip;
        beat     = seg_flip ? seg_val : seg_alt;
      end
      default: beat = seg_val + $urandom_range(0, 31) - 16;
    endcase
    // Set the bit above the sample now and then; the block must ignore it
    if ($urandom_range(0, 15) != 0) beat[DATA_W-1] = 1'b0;
    return beat;
  endfunction

  // Main sequence
  initial begin
    logic [DATA_W-1:0] directed [25];
    sb         = new();
    tail_phase = 1'b0;
    send_calm  = 0;
    seg_left   = 0;
    seg_mode   = 0;
    seg_val    = '0;
    seg_alt    = '0;
    seg_flip   = 1'b0;
    directed   = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
      32'h4000_0000, 32'h2AAA_AAAA, 32'h5555_5555, 32'h3FFF_FFFF, 32'h7FFF_FFFE,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'h8000_0001,
      32'h7FFF_FFFF, 32'h1234_5678, 32'h6DB6_DB6D, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h0000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 32'h7FFF_FFFF, 32'h0000_0002
    };
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes and the ignored top bit while the window still holds reset zeros
    foreach (directed[i]) begin
      sender_idle();
      send_sample(directed[i]);
    end
    wait_drained();

    // Shaped random runs, with one full drain midway and a quiet tail
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) wait_drained();
      if (n == RANDOM_BEATS - TAIL_BEATS) tail_phase <= 1'b1;
      sender_idle();
      send_sample(next_random_beat());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hdl/slwm_pkg.sv
hdl/slwm_store.sv
hdl/slwm_cell.sv
hdl/sliding_window_median_top.sv
sim/tb_sliding_window_median_top.sv
